>>> hw/rtl/ilrs_pkg.sv
package ilrs_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 7;
    localparam int RATING_W = 16;
    localparam int PAYLOAD_W = 32;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_READ   = 3'd3,
        REQ_WRITE  = 3'd4,
        REQ_SORT   = 3'd5
    } req_t;

    // classified operation handed from the front end to the back end
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4,
        OP_SORT   = 3'd5
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [POS_W-1:0]     pos;
        logic [RATING_W-1:0]  rating;
        logic [PAYLOAD_W-1:0] payload;
    } cmd_t;

endpackage

>>> hw/rtl/ilrs_front.sv
module ilrs_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    output logic                  stall_out,
    input  logic [2:0]            req_type,
    input  logic [6:0]            position,
    input  logic [15:0]           rating_in,
    input  logic [31:0]           payload_in,
    // length as the back end will see it after all queued commands
    input  logic [ilrs_pkg::CNT_W-1:0] count_in,
    output logic                  cmd_valid,
    input  logic                  cmd_stall,
    output ilrs_pkg::cmd_t        cmd
);
    import ilrs_pkg::*;

    // two-entry command queue
    cmd_t              q_reg [2];
    cmd_t              q_next0, q_next1;
    logic [1:0]        fill_reg, fill_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic              wr_ptr_reg, wr_ptr_next;
    logic              push, pop;
    cmd_t              c;
    logic [POS_W:0]    cnt_ext;

    // front end only accepts when queue is empty so length is settled
    assign stall_out = (fill_reg != 2'd0);
    assign push = valid_in && !stall_out;
    assign pop  = cmd_valid && !cmd_stall;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd = q_reg[rd_ptr_reg];
    assign cnt_ext = {{(POS_W + 1 - CNT_W){1'b0}}, count_in};

    // classify against current length
    always_comb
    begin
        c.pos     = position;
        c.rating  = rating_in;
        c.payload = payload_in;
        c.op      = OP_NONE;
        unique case (req_type)
            REQ_APPEND:
            begin
                c.pos = cnt_ext[POS_W-1:0];
                if (count_in < CNT_W'(DEPTH)) c.op = OP_INSERT;
            end
            REQ_INSERT:
                if (count_in < CNT_W'(DEPTH) && {1'b0, position} <= cnt_ext) c.op = OP_INSERT;
            REQ_REMOVE:
                if ({1'b0, position} < cnt_ext) c.op = OP_REMOVE;
            REQ_READ:
                if ({1'b0, position} < cnt_ext) c.op = OP_READ;
            REQ_WRITE:
                if ({1'b0, position} < cnt_ext) c.op = OP_WRITE;
            REQ_SORT:
                c.op = OP_SORT;
            default:
                c.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        fill_next   = fill_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        q_next0     = q_reg[0];
        q_next1     = q_reg[1];
        if (push)
        begin
            if (wr_ptr_reg) q_next1 = c;
            else            q_next0 = c;
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) rd_ptr_next = !rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next0;
        q_reg[1] <= q_next1;
    end

endmodule

>>> hw/rtl/ilrs_back.sv
module ilrs_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  ilrs_pkg::cmd_t             cmd,
    output logic [ilrs_pkg::CNT_W-1:0] count_out,
    output logic                       busy,
    output logic                       valid,
    input  logic                       stall,
    output logic                       ok,
    output logic [15:0]                rating_out,
    output logic [31:0]                payload_out,
    output logic [6:0]                 length_out,
    output logic                       is_empty
);
    import ilrs_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_SORT = 2'b10
    } state_t;

    // cell chain
    logic [RATING_W-1:0]  rat_reg [DEPTH];
    logic [PAYLOAD_W-1:0] pay_reg [DEPTH];
    logic [CNT_W-1:0]     count_reg;
    state_t               state_reg;
    logic                 phase_reg;
    logic                 swapped_reg;

    logic                 ovalid_reg, ovalid_next;
    logic                 ok_reg;
    logic [RATING_W-1:0]  rout_reg;
    logic [PAYLOAD_W-1:0] pout_reg;

    logic take, out_free;
    logic [IDX_W-1:0] pidx;
    logic [POS_W:0] cnt_ext;
    logic [POS_W:0] pos_ext;

    assign out_free  = !ovalid_reg || !stall;
    assign cmd_stall = (state_reg != ST_RUN) || !out_free;
    assign take      = cmd_valid && !cmd_stall;
    assign pidx      = cmd.pos[IDX_W-1:0];
    assign cnt_ext   = {{(POS_W + 1 - CNT_W){1'b0}}, count_reg};
    assign pos_ext   = {1'b0, cmd.pos};
    assign count_out = count_reg;
    assign busy      = (state_reg != ST_RUN) || ovalid_reg;

    assign valid       = ovalid_reg;
    assign ok          = ok_reg;
    assign rating_out  = rout_reg;
    assign payload_out = pout_reg;
    assign length_out  = POS_W'(count_reg);
    assign is_empty    = (count_reg == '0);

    // cell updates: shift, write, odd-even transposition sort step
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            if (take && cmd.op == OP_INSERT)
            begin
                if (k == int'(pidx))
                begin
                    rat_reg[k] <= cmd.rating;
                    pay_reg[k] <= cmd.payload;
                end
                else if (k > int'(pidx) && k > 0)
                begin
                    rat_reg[k] <= rat_reg[k-1];
                    pay_reg[k] <= pay_reg[k-1];
                end
            end
            else if (take && cmd.op == OP_REMOVE)
            begin
                if (k >= int'(pidx) && k < DEPTH - 1)
                begin
                    rat_reg[k] <= rat_reg[k+1];
                    pay_reg[k] <= pay_reg[k+1];
                end
            end
            else if (take && cmd.op == OP_WRITE)
            begin
                if (k == int'(pidx))
                begin
                    rat_reg[k] <= cmd.rating;
                    pay_reg[k] <= cmd.payload;
                end
            end
            else if (state_reg == ST_SORT)
            begin
                // pair (k,k+1) with k parity = phase; swap only strictly smaller-first
                if ((k % 2) == int'(phase_reg) && k < DEPTH - 1
                    && (k + 1) < int'(count_reg) && rat_reg[k] < rat_reg[k+1])
                begin
                    rat_reg[k] <= rat_reg[k+1];
                    pay_reg[k] <= pay_reg[k+1];
                end
                else if (k > 0 && ((k - 1) % 2) == int'(phase_reg)
                    && k < int'(count_reg) && rat_reg[k-1] < rat_reg[k])
                begin
                    rat_reg[k] <= rat_reg[k-1];
                    pay_reg[k] <= pay_reg[k-1];
                end
            end
        end
    end

    // swap detector for current sort step
    logic any_swap;
    always_comb
    begin
        any_swap = 1'b0;
        for (int k = 0; k < DEPTH - 1; k++)
            if ((k % 2) == int'(phase_reg) && (k + 1) < int'(count_reg)
                && rat_reg[k] < rat_reg[k+1])
                any_swap = 1'b1;
    end

    // result valid: held while stalled, set by a finished command or sort
    always_comb
    begin
        ovalid_next = ovalid_reg && stall;
        if (state_reg == ST_RUN && take && cmd.op != OP_SORT)
            ovalid_next = 1'b1;
        if (state_reg == ST_SORT && phase_reg && !swapped_reg && !any_swap)
            ovalid_next = 1'b1;
    end

    // control, length and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            state_reg   <= ST_RUN;
            phase_reg   <= 1'b0;
            swapped_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
            ok_reg      <= 1'b0;
            rout_reg    <= '0;
            pout_reg    <= '0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            unique case (state_reg)
                ST_RUN:
                    if (take)
                    begin
                        rout_reg <= '0;
                        pout_reg <= '0;
                        ok_reg   <= (cmd.op != OP_NONE);
                        unique case (cmd.op)
                            OP_INSERT: count_reg <= count_reg + 1'b1;
                            OP_REMOVE: count_reg <= count_reg - 1'b1;
                            OP_READ:
                            begin
                                rout_reg <= rat_reg[pidx];
                                pout_reg <= pay_reg[pidx];
                            end
                            default: ;
                        endcase
                        if (cmd.op == OP_SORT)
                        begin
                            state_reg   <= ST_SORT;
                            phase_reg   <= 1'b0;
                            swapped_reg <= 1'b0;
                        end
                    end
                ST_SORT:
                begin
                    // done after an even+odd phase pair without swaps
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        if (!swapped_reg && !any_swap)
                            state_reg <= ST_RUN;
                        swapped_reg <= 1'b0;
                    end
                    else
                        swapped_reg <= any_swap;
                end
                default: state_reg <= ST_RUN;
            endcase
        end
    end

endmodule

>>> hw/rtl/indexed_list_with_rating_sort_core.sv
// Edits and reads pass the front command queue, then the back-end result register;
// a sort runs odd-even transposition phases until an even+odd pair makes no swap.
// A new transaction is stalled at the input until the previous result has been taken
// by the receiver.
// Reset (rst_n, async, low): list empties; stored records are not cleared.
module indexed_list_with_rating_sort_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [6:0]  position,
    input  logic [15:0] rating_in,
    input  logic [31:0] payload_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [15:0] rating_out,
    output logic [31:0] payload_out,
    output logic [6:0]  length_out,
    output logic        is_empty
);
    import ilrs_pkg::*;

    logic             cmd_valid, cmd_stall, back_busy, fstall;
    cmd_t             cmd;
    logic [CNT_W-1:0] count;

    // hold new transactions while the back end still works on one
    assign in_stall = fstall || back_busy || cmd_valid;

    ilrs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (in_valid && !back_busy),
        .stall_out  (fstall),
        .req_type   (req_type),
        .position   (position),
        .rating_in  (rating_in),
        .payload_in (payload_in),
        .count_in   (count),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd)
    );

    ilrs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .count_out   (count),
        .busy        (back_busy),
        .valid       (out_valid),
        .stall       (out_stall),
        .ok          (ok),
        .rating_out  (rating_out),
        .payload_out (payload_out),
        .length_out  (length_out),
        .is_empty    (is_empty)
    );

endmodule

>>> hw/rtl/ilrs_checker.sv
module ilrs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] length_out,
    input logic       is_empty
);
    // empty flag tracks length
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (length_out == 7'd0)))
        else $error("is_empty disagrees with length");

    // length never beyond capacity
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (length_out <= 7'd64))
        else $error("length beyond capacity");

    // accepted transaction keeps the input stalled in the next cycle
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transaction taken too early");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(length_out)))
        else $error("stalled result changed");

endmodule

bind indexed_list_with_rating_sort_core ilrs_checker u_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .length_out (length_out),
    .is_empty   (is_empty)
);

>>> verif/ilrs_list_checker.sv
module ilrs_list_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [6:0]  position,
    input  logic [15:0] rating_in,
    input  logic [31:0] payload_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        ok,
    input  logic [15:0] rating_out,
    input  logic [31:0] payload_out,
    input  logic [6:0]  length_out,
    input  logic        is_empty,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ilrs_pkg::*;

    typedef struct packed {
        logic        ok;
        logic [15:0] rating;
        logic [31:0] payload;
        logic [6:0]  length;
        logic        empty;
    } list_answer_t;

    logic [RATING_W-1:0]  shadow_rating [DEPTH];
    logic [PAYLOAD_W-1:0] shadow_payload [DEPTH];
    int                   shadow_len;
    list_answer_t         answer_q [$];

    // stable descending insertion sort on the shadow list
    function automatic void shadow_sort();
        logic [15:0] key;
        logic [31:0] pay;
        int j;
        for (int i = 1; i < shadow_len; i++)
        begin
            key = shadow_rating[i];
            pay = shadow_payload[i];
            j = i;
            while (j > 0 && shadow_rating[j-1] < key)
            begin
                shadow_rating[j] = shadow_rating[j-1];
                shadow_payload[j] = shadow_payload[j-1];
                j--;
            end
            shadow_rating[j] = key;
            shadow_payload[j] = pay;
        end
    endfunction

    function automatic list_answer_t apply_request(logic [2:0] kind, int pos,
                                                   logic [15:0] rt, logic [31:0] pl);
        list_answer_t a;
        a = '0;
        case (kind)
            REQ_APPEND:
                if (shadow_len < DEPTH)
                begin
                    shadow_rating[shadow_len] = rt;
                    shadow_payload[shadow_len] = pl;
                    shadow_len++;
                    a.ok = 1'b1;
                end
            REQ_INSERT:
                if (shadow_len < DEPTH && pos <= shadow_len)
                begin
                    for (int k = shadow_len; k > pos; k--)
                    begin
                        shadow_rating[k] = shadow_rating[k-1];
                        shadow_payload[k] = shadow_payload[k-1];
                    end
                    shadow_rating[pos] = rt;
                    shadow_payload[pos] = pl;
                    shadow_len++;
                    a.ok = 1'b1;
                end
            REQ_REMOVE:
                if (pos < shadow_len)
                begin
                    for (int k = pos; k + 1 < shadow_len; k++)
                    begin
                        shadow_rating[k] = shadow_rating[k+1];
                        shadow_payload[k] = shadow_payload[k+1];
                    end
                    shadow_len--;
                    a.ok = 1'b1;
                end
            REQ_READ:
                if (pos < shadow_len)
                begin
                    a.rating = shadow_rating[pos];
                    a.payload = shadow_payload[pos];
                    a.ok = 1'b1;
                end
            REQ_WRITE:
                if (pos < shadow_len)
                begin
                    shadow_rating[pos] = rt;
                    shadow_payload[pos] = pl;
                    a.ok = 1'b1;
                end
            REQ_SORT:
            begin
                shadow_sort();
                a.ok = 1'b1;
            end
            default: ;
        endcase
        a.length = shadow_len[6:0];
        a.empty = (shadow_len == 0);
        return a;
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge clk or negedge rst_n)
    begin
        list_answer_t want;
        if (!rst_n)
        begin
            shadow_len = 0;
            answer_q.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (ok !== want.ok)
                    begin
                        $error("ok: expected %0h, got %0h", want.ok, ok);
                        fail_count++;
                    end
                    if (rating_out !== want.rating)
                    begin
                        $error("rating_out: expected %0h, got %0h", want.rating, rating_out);
                        fail_count++;
                    end
                    if (payload_out !== want.payload)
                    begin
                        $error("payload_out: expected %0h, got %0h", want.payload,
                               payload_out);
                        fail_count++;
                    end
                    if (length_out !== want.length)
                    begin
                        $error("length_out: expected %0d, got %0d", want.length, length_out);
                        fail_count++;
                    end
                    if (is_empty !== want.empty)
                    begin
                        $error("is_empty: expected %0h, got %0h", want.empty, is_empty);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                answer_q.push_back(apply_request(req_type, int'(position), rating_in,
                                                 payload_in));
            pending_count = answer_q.size();
        end
    end
endmodule

>>> verif/tb_indexed_list_with_rating_sort_core.sv
module tb_indexed_list_with_rating_sort_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ilrs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  req_type;
    logic [6:0]  position;
    logic [15:0] rating_in;
    logic [31:0] payload_in;
    logic        out_valid;
    logic        out_stall;
    logic        ok;
    logic [15:0] rating_out;
    logic [31:0] payload_out;
    logic [6:0]  length_out;
    logic        is_empty;
    int          fail_count;
    int          pending_count;
    int          idle_cycles;
    bit          calm_phase;
    bit          hold_off;
    int          tb_len;

    indexed_list_with_rating_sort_core i_dut (.*);

    ilrs_list_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random stalls, a quiet stretch and one long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if (calm_phase)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 25);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_indexed_list_with_rating_sort_core: done, errors");
            $finish;
        end
    end

    // one request; sender gap before it, then wait for acceptance
    task automatic send_req(logic [2:0] kind, logic [6:0] pos, logic [15:0] rt,
                            logic [31:0] pl);
        while (!calm_phase && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        position <= pos;
        rating_in <= rt;
        payload_in <= pl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // track length for shaping positions
        case (kind)
            REQ_APPEND: if (tb_len < DEPTH) tb_len++;
            REQ_INSERT: if (tb_len < DEPTH && pos <= tb_len) tb_len++;
            REQ_REMOVE: if (pos < tb_len) tb_len--;
            default: ;
        endcase
    endtask

    function automatic logic [6:0] pick_pos();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 7'($urandom_range(127));
        else if (r == 1)
            return tb_len[6:0];
        else if (tb_len == 0)
            return 7'd0;
        else
            return 7'($urandom_range(tb_len - 1));
    endfunction

    function automatic logic [15:0] pick_rating();
        // small keys often, so sort ties happen
        return ($urandom_range(1)) ? 16'($urandom_range(7)) : 16'($urandom);
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 2) return 3'($urandom_range(7, 6));
        if (r < 5) return REQ_SORT;
        if (r < 25) return (tb_len > 50) ? REQ_REMOVE : REQ_APPEND;
        if (r < 45) return REQ_INSERT;
        if (r < 60) return REQ_REMOVE;
        if (r < 80) return REQ_READ;
        return REQ_WRITE;
    endfunction

    initial
    begin
        int wait_cnt;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = '0;
        position = '0;
        rating_in = '0;
        payload_in = '0;
        hold_off = 1'b0;
        calm_phase = 1'b0;
        tb_len = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list cases, extremes, unused types, full list
        send_req(REQ_READ, 7'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_req(REQ_REMOVE, 7'd0, 16'h0, 32'h0);
        send_req(REQ_WRITE, 7'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_req(REQ_SORT, 7'd0, 16'h0, 32'h0);
        send_req(REQ_INSERT, 7'd1, 16'h1, 32'h1);
        send_req(REQ_APPEND, 7'd127, 16'hFFFF, 32'hFFFF_FFFF);
        send_req(REQ_SORT, 7'd0, 16'h0, 32'h0);
        send_req(REQ_INSERT, 7'd1, 16'h0, 32'h0);
        send_req(REQ_INSERT, 7'd0, 16'h8000, 32'h8000_0000);
        send_req(REQ_READ, 7'd2, 16'h0, 32'h0);
        send_req(REQ_READ, 7'd3, 16'h0, 32'h0);
        send_req(3'd6, 7'd0, 16'h0, 32'h0);
        send_req(3'd7, 7'd127, 16'hFFFF, 32'hFFFF_FFFF);
        send_req(REQ_SORT, 7'd0, 16'h0, 32'h0);
        send_req(REQ_WRITE, 7'd2, 16'h5, 32'h5);
        send_req(REQ_REMOVE, 7'd2, 16'h0, 32'h0);
        send_req(REQ_REMOVE, 7'd0, 16'h0, 32'h0);
        // fill to full, with the receiver held off so the block backs up
        hold_off = 1'b1;
        fork
            begin
                wait_cnt = 0;
                while (wait_cnt < 300)
                begin
                    @(posedge clk);
                    wait_cnt++;
                end
                hold_off = 1'b0;
            end
        join_none
        while (tb_len < DEPTH)
            send_req(REQ_APPEND, 7'd0, pick_rating(), $urandom);
        send_req(REQ_APPEND, 7'd0, 16'h1, 32'h1);
        send_req(REQ_INSERT, 7'd0, 16'h1, 32'h1);
        send_req(REQ_SORT, 7'd0, 16'h0, 32'h0);
        send_req(REQ_READ, 7'd63, 16'h0, 32'h0);
        send_req(REQ_READ, 7'd64, 16'h0, 32'h0);

        // random traffic, with a stall-free stretch in the middle
        for (int n = 0; n < 1800; n++)
        begin
            calm_phase = (n >= 700 && n < 950);
            send_req(pick_kind(), pick_pos(), pick_rating(), $urandom);
        end
        calm_phase = 1'b0;
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb_indexed_list_with_rating_sort_core: done, clean");
        else
            $display("tb_indexed_list_with_rating_sort_core: done, errors");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/ilrs_pkg.sv
hw/rtl/ilrs_front.sv
hw/rtl/ilrs_back.sv
hw/rtl/indexed_list_with_rating_sort_core.sv
hw/rtl/ilrs_checker.sv
verif/ilrs_list_checker.sv
verif/tb_indexed_list_with_rating_sort_core.sv
